[rtl/fan_pid_drive_controller_core_assert.svh]
// ----------------------------------------------------------------------------
// Fan PID drive controller: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FAN_PID_DRIVE_CONTROLLER_CORE_ASSERT_SVH
`define FAN_PID_DRIVE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fan pid drive controller: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fan pid drive controller: assertion failed");

`endif

[rtl/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg
// Widths, register indexes, microcode fields and program for the fan PID
// drive controller.
// ----------------------------------------------------------------------------
package fpd_pkg;

    // Fraction bits of the integral term and the drive accumulator
    localparam int FRAC_BITS = 8;
    localparam int UP_SH     = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int DN_SH     = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
    localparam int DUTY_MAX  = 255;

    localparam int TEMP_W    = 8;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int SECS_W    = 16;
    localparam int ERR_W     = 10;
    localparam int DIFF_W    = 11;
    localparam int MA_W      = GAIN_W + ERR_W;          // gain * error
    localparam int MB_W      = SECS_W + 1;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int DMAG_W    = GAIN_W + DIFF_W;         // |gain_deriv * diff|
    localparam int NUM_W     = DMAG_W + UP_SH;
    localparam int DEN_W     = SECS_W + DN_SH;
    localparam int ACC_W     = PROD_W + UP_SH + 5;
    localparam int INTEG_W   = LIMIT_W + UP_SH + 1;
    localparam int DRV_W     = 8 + FRAC_BITS;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = CFG_IDX_W'(7);

    typedef enum logic [1:0] {MA_GP, MA_GI, MA_GD, MA_PROD} t_mul_a;
    typedef enum logic [1:0] {MB_ERR, MB_DIFF, MB_SECS} t_mul_b;
    typedef enum logic [1:0] {ACC_NONE, ACC_LOAD_P, ACC_ADD_INTEG, ACC_ADD_QUOT} t_acc_op;
    typedef enum logic [1:0] {INTEG_NONE, INTEG_SUM, INTEG_CLAMP} t_integ_op;
    typedef enum logic [1:0] {WAIT_NONE, WAIT_DIV, WAIT_OUT} t_wait;

    typedef struct packed {
        t_mul_a    mul_a;
        t_mul_b    mul_b;
        logic      mul_en;
        t_acc_op   acc_op;
        t_integ_op integ_op;
        logic      div_start;
        t_wait     wait_on;
        logic      finish;
    } t_ctrl;

    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } t_status;

    localparam t_ctrl CTRL_NOP = '{MA_GP, MB_ERR, 1'b0, ACC_NONE, INTEG_NONE, 1'b0,
                                   WAIT_NONE, 1'b0};

    localparam int PROG_LEN = 9;
    localparam int PC_W     = $clog2(PROG_LEN);

    // Update program: P, I and D products on the shared multiplier,
    // integral clamp, serial divide for D, then output clamp.
    function automatic t_ctrl rom_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = CTRL_NOP;
        case (pc)
            PC_W'(0): begin
                w.mul_en = 1'b1; w.mul_a = MA_GP; w.mul_b = MB_ERR;
            end
            PC_W'(1): begin
                w.mul_en = 1'b1; w.mul_a = MA_GI; w.mul_b = MB_ERR;
                w.acc_op = ACC_LOAD_P;
            end
            PC_W'(2): begin
                w.mul_en = 1'b1; w.mul_a = MA_PROD; w.mul_b = MB_SECS;
            end
            PC_W'(3): begin
                w.mul_en = 1'b1; w.mul_a = MA_GD; w.mul_b = MB_DIFF;
                w.integ_op = INTEG_SUM;
            end
            PC_W'(4): begin
                w.integ_op = INTEG_CLAMP;
            end
            PC_W'(5): begin
                w.acc_op = ACC_ADD_INTEG; w.div_start = 1'b1;
            end
            PC_W'(6): begin
                w.wait_on = WAIT_DIV;
            end
            PC_W'(7): begin
                w.acc_op = ACC_ADD_QUOT;
            end
            PC_W'(8): begin
                w.wait_on = WAIT_OUT; w.finish = 1'b1;
            end
            default: w = CTRL_NOP;
        endcase
        return w;
    endfunction

    // Q8.8 product to accumulator scale, truncating toward zero
    function automatic logic signed [ACC_W-1:0] q8_scale(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] up;
        logic signed [ACC_W-1:0] bias;
        up   = v <<< UP_SH;
        bias = v[ACC_W-1] ? $signed((ACC_W'(1) << DN_SH) - ACC_W'(1)) : '0;
        return (up + bias) >>> DN_SH;
    endfunction

endpackage

[rtl/fpd_div.sv]
// ----------------------------------------------------------------------------
// fpd_div
// Restoring divider, one quotient bit a cycle, with signed result truncated
// toward zero.
// ----------------------------------------------------------------------------
module fpd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_neg,
    input  logic [fpd_pkg::NUM_W-1:0]           i_num,
    input  logic [fpd_pkg::DEN_W-1:0]           i_den,
    output logic                                o_busy,
    output logic signed [fpd_pkg::NUM_W:0]      o_quot
);

    localparam int CNT_W = $clog2(fpd_pkg::NUM_W + 1);

    logic                         r_busy;
    logic [CNT_W-1:0]             r_cnt;
    logic [fpd_pkg::NUM_W-1:0]    r_quo;
    logic [fpd_pkg::DEN_W-1:0]    r_rem;
    logic [fpd_pkg::DEN_W-1:0]    r_den;
    logic                         r_neg;

    logic [fpd_pkg::DEN_W:0]      s_shift;
    logic [fpd_pkg::DEN_W:0]      s_trial;
    logic                         s_fits;

    assign s_shift = {r_rem, r_quo[fpd_pkg::NUM_W-1]};
    assign s_trial = s_shift - {1'b0, r_den};
    assign s_fits  = !s_trial[fpd_pkg::DEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(fpd_pkg::NUM_W);
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_neg  <= i_neg;
        end else if (r_busy) begin
            r_rem <= s_fits ? s_trial[fpd_pkg::DEN_W-1:0] : s_shift[fpd_pkg::DEN_W-1:0];
            r_quo <= {r_quo[fpd_pkg::NUM_W-2:0], s_fits};
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

[rtl/fpd_seq.sv]
// ----------------------------------------------------------------------------
// fpd_seq
// Microcode sequencer: step counter over the update program, with holds on
// the divider and the output register.
// ----------------------------------------------------------------------------
module fpd_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  fpd_pkg::t_status     i_status,
    output fpd_pkg::t_ctrl       o_ctrl,
    output logic                 o_run
);

    logic                        r_run;
    logic [fpd_pkg::PC_W-1:0]    r_pc;
    fpd_pkg::t_ctrl              s_word;
    logic                        s_hold;

    assign s_word = fpd_pkg::rom_word(r_pc);

    always_comb begin
        unique case (s_word.wait_on)
            fpd_pkg::WAIT_DIV: s_hold = i_status.div_busy;
            fpd_pkg::WAIT_OUT: s_hold = i_status.out_busy;
            default:           s_hold = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
        end else if (!r_run) begin
            if (i_start) begin
                r_run <= 1'b1;
                r_pc  <= '0;
            end
        end else if (!s_hold) begin
            if (s_word.finish) begin
                r_run <= 1'b0;
                r_pc  <= '0;
            end else begin
                r_pc <= r_pc + fpd_pkg::PC_W'(1);
            end
        end
    end

    // Suppress the word while holding so that its actions run once
    assign o_ctrl = (r_run && !s_hold) ? s_word : fpd_pkg::CTRL_NOP;
    assign o_run  = r_run;

endmodule

[rtl/fan_pid_drive_controller_core.sv]
// ----------------------------------------------------------------------------
// fan_pid_drive_controller_core
// Incremental PID fan drive: keeps the hottest temperature of a round and,
// on the last item, updates the drive accumulator under microcode control.
//
//   Channel  Handshake                 Payload
//   in       i_in_valid / o_in_ready   i_drive_temp, i_last_drive, i_elapsed_secs
//   out      o_out_valid / i_out_ready o_duty, o_round_max_temp, o_forced_full
//   cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A non-last item, or a last item with zero elapsed seconds, is accepted without
// starting the program. An update runs the program, which holds at the divide
// step while the bit-serial divider forms its NUM_W (27) quotient bits for the
// derivative term; the result is registered at the final step of the program.
// Reset is synchronous, active low; configuration and controller state registers
// return to their reset values, the working and output data registers do not.
// A stalled output holds the program at its final step; input waits until
// the program has finished.
// ----------------------------------------------------------------------------
`include "fan_pid_drive_controller_core_assert.svh"

module fan_pid_drive_controller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_drive_temp,
    input  logic                              i_last_drive,
    input  logic [15:0]                       i_elapsed_secs,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_duty,
    output logic [7:0]                        o_round_max_temp,
    output logic                              o_forced_full,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ACC_W  = fpd_pkg::ACC_W;
    localparam int PROD_W = fpd_pkg::PROD_W;
    localparam int FRAC   = fpd_pkg::FRAC_BITS;

    // Configuration
    logic [7:0]                          r_target;
    logic [7:0]                          r_overheat;
    logic [7:0]                          r_min_duty;
    logic signed [fpd_pkg::GAIN_W-1:0]   r_gain_p;
    logic signed [fpd_pkg::GAIN_W-1:0]   r_gain_i;
    logic signed [fpd_pkg::GAIN_W-1:0]   r_gain_d;
    logic [fpd_pkg::LIMIT_W-1:0]         r_limit;

    // Controller state
    logic [7:0]                          r_hottest;
    logic signed [fpd_pkg::INTEG_W-1:0]  r_integ;
    logic signed [fpd_pkg::ERR_W-1:0]    r_last_err;
    logic [fpd_pkg::DRV_W-1:0]           r_drive;

    // Working registers of one update
    logic [7:0]                          r_rmax;
    logic signed [fpd_pkg::ERR_W-1:0]    r_err;
    logic signed [fpd_pkg::DIFF_W-1:0]   r_diff;
    logic [fpd_pkg::SECS_W-1:0]          r_secs;
    logic signed [PROD_W-1:0]            r_mul;
    logic signed [ACC_W-1:0]             r_acc;
    logic signed [ACC_W-1:0]             r_tsum;

    logic                                r_out_valid;
    logic [7:0]                          r_duty;
    logic [7:0]                          r_out_max;
    logic                                r_forced;

    fpd_pkg::t_ctrl                      s_ctrl;
    fpd_pkg::t_status                    s_status;
    logic                                s_run;
    logic                                s_in_acc;
    logic                                s_start;
    logic [7:0]                          n_max;
    logic signed [fpd_pkg::ERR_W-1:0]    s_err;
    logic signed [fpd_pkg::MA_W-1:0]     s_ma;
    logic signed [fpd_pkg::MB_W-1:0]     s_mb;
    logic signed [PROD_W-1:0]            s_prod;
    logic signed [ACC_W-1:0]             s_mul_q8;
    logic signed [ACC_W-1:0]             s_lim;
    logic signed [ACC_W-1:0]             s_full;
    logic signed [ACC_W-1:0]             s_floor;
    logic                                s_dneg;
    logic [PROD_W-1:0]                   s_dabs;
    logic [fpd_pkg::NUM_W-1:0]           s_num;
    logic [fpd_pkg::DEN_W-1:0]           s_den;
    logic                                s_div_busy;
    logic signed [fpd_pkg::NUM_W:0]      s_quot;
    logic                                s_forced;
    logic [fpd_pkg::DRV_W-1:0]           n_drive;

    assign o_in_ready  = !s_run;
    assign o_cfg_ready = 1'b1;
    assign s_in_acc    = i_in_valid && o_in_ready;
    assign n_max       = (i_drive_temp > r_hottest) ? i_drive_temp : r_hottest;
    assign s_err       = $signed({2'b00, n_max}) - $signed({2'b00, r_target});
    assign s_start     = s_in_acc && i_last_drive && (i_elapsed_secs != '0);

    assign s_status.div_busy = s_div_busy;
    assign s_status.out_busy = r_out_valid && !i_out_ready;

    fpd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_start),
        .i_status (s_status),
        .o_ctrl   (s_ctrl),
        .o_run    (s_run)
    );

    // Shared multiplier operands
    always_comb begin
        unique case (s_ctrl.mul_a)
            fpd_pkg::MA_GP:   s_ma = fpd_pkg::MA_W'(r_gain_p);
            fpd_pkg::MA_GI:   s_ma = fpd_pkg::MA_W'(r_gain_i);
            fpd_pkg::MA_GD:   s_ma = fpd_pkg::MA_W'(r_gain_d);
            default:          s_ma = r_mul[fpd_pkg::MA_W-1:0];
        endcase
        unique case (s_ctrl.mul_b)
            fpd_pkg::MB_ERR:  s_mb = fpd_pkg::MB_W'(r_err);
            fpd_pkg::MB_DIFF: s_mb = fpd_pkg::MB_W'(r_diff);
            default:          s_mb = $signed({1'b0, r_secs});
        endcase
    end

    assign s_prod   = s_ma * s_mb;
    assign s_mul_q8 = fpd_pkg::q8_scale(ACC_W'(r_mul));
    assign s_lim    = $signed((ACC_W'(r_limit) << fpd_pkg::UP_SH) >> fpd_pkg::DN_SH);
    assign s_full   = $signed(ACC_W'(fpd_pkg::DUTY_MAX) << FRAC);
    assign s_floor  = $signed(ACC_W'(r_min_duty) << FRAC);

    // Derivative divide: magnitude of gain_deriv * diff over scaled seconds
    assign s_dneg = r_mul[PROD_W-1];
    assign s_dabs = s_dneg ? PROD_W'(-r_mul) : PROD_W'(r_mul);
    assign s_num  = fpd_pkg::NUM_W'(s_dabs[fpd_pkg::DMAG_W-1:0]) << fpd_pkg::UP_SH;
    assign s_den  = fpd_pkg::DEN_W'(r_secs) << fpd_pkg::DN_SH;

    fpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_ctrl.div_start),
        .i_neg   (s_dneg),
        .i_num   (s_num),
        .i_den   (s_den),
        .o_busy  (s_div_busy),
        .o_quot  (s_quot)
    );

    // Final clamp of the accumulator
    assign s_forced = r_rmax > r_overheat;
    always_comb begin
        if (s_forced || r_acc > s_full) begin
            n_drive = fpd_pkg::DRV_W'(s_full);
        end else if (r_acc < s_floor) begin
            n_drive = fpd_pkg::DRV_W'(s_floor);
        end else begin
            n_drive = fpd_pkg::DRV_W'(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 8'd37;
            r_overheat  <= 8'd50;
            r_min_duty  <= 8'd80;
            r_gain_p    <= 16'sd256;
            r_gain_i    <= '0;
            r_limit     <= 15'd2560;
            r_gain_d    <= '0;
            r_hottest   <= '0;
            r_integ     <= '0;
            r_last_err  <= '0;
            r_drive     <= fpd_pkg::DRV_W'(128) << FRAC;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fpd_pkg::CFG_TARGET:   r_target   <= i_cfg_data[7:0];
                    fpd_pkg::CFG_OVERHEAT: r_overheat <= i_cfg_data[7:0];
                    fpd_pkg::CFG_MIN_DUTY: r_min_duty <= i_cfg_data[7:0];
                    fpd_pkg::CFG_INIT:     r_drive    <= {i_cfg_data[7:0], FRAC'(0)};
                    fpd_pkg::CFG_GAIN_P:   r_gain_p   <= $signed(i_cfg_data);
                    fpd_pkg::CFG_GAIN_I:   r_gain_i   <= $signed(i_cfg_data);
                    fpd_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data[fpd_pkg::LIMIT_W-1:0];
                    fpd_pkg::CFG_GAIN_D:   r_gain_d   <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // Round maximum; clear at every end of round
            if (s_in_acc) begin
                r_hottest <= i_last_drive ? 8'd0 : n_max;
            end
            if (s_start) begin
                r_rmax <= n_max;
                r_secs <= i_elapsed_secs;
                r_err  <= s_err;
                r_diff <= fpd_pkg::DIFF_W'(s_err) - fpd_pkg::DIFF_W'(r_last_err);
            end

            if (s_ctrl.mul_en) begin
                r_mul <= s_prod;
            end

            case (s_ctrl.acc_op)
                fpd_pkg::ACC_LOAD_P:    r_acc <= $signed(ACC_W'(r_drive)) + s_mul_q8;
                fpd_pkg::ACC_ADD_INTEG: r_acc <= r_acc + ACC_W'(r_integ);
                fpd_pkg::ACC_ADD_QUOT:  r_acc <= r_acc + ACC_W'(s_quot);
                default: ;
            endcase

            case (s_ctrl.integ_op)
                fpd_pkg::INTEG_SUM: r_tsum <= ACC_W'(r_integ) + s_mul_q8;
                fpd_pkg::INTEG_CLAMP: begin
                    if (r_tsum > s_lim) begin
                        r_integ <= fpd_pkg::INTEG_W'(s_lim);
                    end else if (r_tsum < -s_lim) begin
                        r_integ <= fpd_pkg::INTEG_W'(-s_lim);
                    end else begin
                        r_integ <= fpd_pkg::INTEG_W'(r_tsum);
                    end
                end
                default: ;
            endcase

            if (s_ctrl.finish) begin
                r_drive     <= n_drive;
                r_last_err  <= r_err;
                r_out_valid <= 1'b1;
                r_duty      <= n_drive[fpd_pkg::DRV_W-1:FRAC];
                r_out_max   <= r_rmax;
                r_forced    <= s_forced;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_duty           = r_duty;
    assign o_round_max_temp = r_out_max;
    assign o_forced_full    = r_forced;

    `FPD_ASSERT_NOW(a_forced_is_full, i_clk, i_rst_n, o_out_valid && o_forced_full, o_duty == 8'd255)
    `FPD_ASSERT_NOW(a_duty_floor, i_clk, i_rst_n, o_out_valid, (o_duty == 8'd255) || (o_duty >= r_min_duty))
    `FPD_ASSERT_NOW(a_idle_divider, i_clk, i_rst_n, o_in_ready, !s_div_busy)
    `FPD_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, s_start, !o_in_ready)

endmodule

[test/fan_pid_drive_controller_core_test.sv]
// ----------------------------------------------------------------------------
// fan_pid_drive_controller_core_test
// Self-checking bench for the fan PID drive controller. A queue of polling
// rounds feeds a valid/ready driver, and a monitor predicts each duty update
// from its own copy of the controller state. It then checks the results in
// order, across several register settings and idle patterns.
// ----------------------------------------------------------------------------
module fan_pid_drive_controller_core_test;

    localparam int     SETTLE_CYCLES = 100;
    localparam int     STALL_LIMIT   = 3000;
    localparam int     PHASES        = 9;
    localparam int     PHASE_ITEMS   = 128;
    localparam longint Q_UP          = 64'sd1 <<< fpd_pkg::UP_SH;
    localparam longint Q_DN          = 64'sd1 <<< fpd_pkg::DN_SH;

    typedef struct packed {
        logic [7:0]  temp;
        logic        is_last;
        logic [15:0] secs;
    } t_drive_item;

    typedef struct packed {
        logic [7:0] duty;
        logic [7:0] round_max;
        logic       forced;
    } t_duty_result;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           in_valid    = 1'b0;
    logic [7:0]                     in_temp     = '0;
    logic                           in_last     = 1'b0;
    logic [15:0]                    in_secs     = '0;
    logic                           out_ready   = 1'b0;
    logic                           cfg_valid   = 1'b0;
    logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [fpd_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                           o_in_ready;
    logic                           o_out_valid;
    logic [7:0]                     o_duty;
    logic [7:0]                     o_round_max_temp;
    logic                           o_forced_full;
    logic                           o_cfg_ready;

    t_drive_item  poll_q[$];
    t_duty_result duty_due_q[$];
    logic         in_fire       = 1'b0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           idle_cycles   = 0;
    int           errors        = 0;

    // Controller copy: registers
    logic [7:0] set_temp, hot_limit, duty_floor, duty_init;
    int         k_p, k_i, k_d, integ_cap;
    // Controller copy: state
    logic [7:0] hot_temp;
    longint     integ_acc, drive_acc;
    int         prev_err;

    fan_pid_drive_controller_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_drive_temp     (in_temp),
        .i_last_drive     (in_last),
        .i_elapsed_secs   (in_secs),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_duty           (o_duty),
        .o_round_max_temp (o_round_max_temp),
        .o_forced_full    (o_forced_full),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Q8.8 product to accumulator scale, truncating toward zero
    function automatic longint to_acc(input longint v);
        return (v * Q_UP) / Q_DN;
    endfunction

    function automatic void apply_cfg(input logic [fpd_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [fpd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            fpd_pkg::CFG_TARGET:   set_temp = data[7:0];
            fpd_pkg::CFG_OVERHEAT: hot_limit = data[7:0];
            fpd_pkg::CFG_MIN_DUTY: duty_floor = data[7:0];
            fpd_pkg::CFG_INIT: begin
                duty_init = data[7:0];
                drive_acc = longint'(data[7:0]) <<< fpd_pkg::FRAC_BITS;
            end
            fpd_pkg::CFG_GAIN_P:   k_p = int'($signed(data));
            fpd_pkg::CFG_GAIN_I:   k_i = int'($signed(data));
            fpd_pkg::CFG_LIMIT:    integ_cap = int'(data[14:0]);
            fpd_pkg::CFG_GAIN_D:   k_d = int'($signed(data));
            default: ;
        endcase
    endfunction

    // One temperature in; returns 1 with the new duty when the round closes
    function automatic bit fan_update(input logic [7:0] temp, input logic is_last,
                                      input logic [15:0] secs,
                                      output t_duty_result res);
        int         err;
        longint     pterm, dterm, lim, full, floor_v;
        logic [7:0] rmax;
        bit         forced;
        res = '0;
        if (temp > hot_temp)
            hot_temp = temp;
        if (!is_last)
            return 1'b0;
        rmax = hot_temp;
        hot_temp = '0;
        if (secs == 16'd0)
            return 1'b0;
        err = int'(rmax) - int'(set_temp);
        pterm = to_acc(longint'(k_p) * longint'(err));
        integ_acc += to_acc(longint'(k_i) * longint'(err) * longint'(secs));
        lim = to_acc(longint'(integ_cap));
        if (integ_acc > lim)
            integ_acc = lim;
        else if (integ_acc < -lim)
            integ_acc = -lim;
        dterm = (longint'(k_d) * longint'(err - prev_err) * Q_UP) / (longint'(secs) * Q_DN);
        prev_err = err;
        drive_acc += pterm + integ_acc + dterm;
        full = longint'(fpd_pkg::DUTY_MAX) <<< fpd_pkg::FRAC_BITS;
        floor_v = longint'(duty_floor) <<< fpd_pkg::FRAC_BITS;
        forced = rmax > hot_limit;
        if (forced || drive_acc > full)
            drive_acc = full;
        else if (drive_acc < floor_v)
            drive_acc = floor_v;
        res.duty = 8'(drive_acc >>> fpd_pkg::FRAC_BITS);
        res.round_max = rmax;
        res.forced = forced;
        return 1'b1;
    endfunction

    // Driver: present queued items, hold each until its transaction completes
    always @(negedge i_clk) begin : driver
        t_drive_item nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            if (in_valid && !in_fire) begin
                // hold
            end else if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = poll_q.pop_front();
                in_valid <= 1'b1;
                in_temp <= nxt.temp;
                in_last <= nxt.is_last;
                in_secs <= nxt.secs;
            end else begin
                in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_duty_result got, want;
        in_fire <= in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && out_ready) begin
            got.duty = o_duty;
            got.round_max = o_round_max_temp;
            got.forced = o_forced_full;
            if (duty_due_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got duty %0d max %0d full %0b",
                         $time, got.duty, got.round_max, got.forced);
            end else begin
                want = duty_due_q.pop_front();
                if (got.duty !== want.duty) begin
                    errors++;
                    $display("%0t: duty: expected %0d, got %0d", $time, want.duty, got.duty);
                end
                if (got.round_max !== want.round_max) begin
                    errors++;
                    $display("%0t: round_max_temp: expected %0d, got %0d",
                             $time, want.round_max, got.round_max);
                end
                if (got.forced !== want.forced) begin
                    errors++;
                    $display("%0t: forced_full: expected %0b, got %0b",
                             $time, want.forced, got.forced);
                end
            end
        end
        if (in_valid && o_in_ready) begin
            if (fan_update(in_temp, in_last, in_secs, want))
                duty_due_q.push_back(want);
        end
        if (cfg_valid && o_cfg_ready)
            apply_cfg(cfg_index, cfg_data);
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("fan_pid_drive_controller_core_test: done, errors");
        $finish;
    end

    task automatic add_item(input logic [7:0] temp, input logic is_last,
                            input logic [15:0] secs);
        t_drive_item it;
        it.temp = temp;
        it.is_last = is_last;
        it.secs = secs;
        poll_q.push_back(it);
    endtask

    task automatic write_reg(input logic [fpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic logic [15:0] pick_gain(input int span);
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Mostly near the setpoint; some anywhere, some unreadable
    function automatic logic [7:0] pick_temp();
        int r, t;
        r = $urandom_range(99);
        if (r < 70) begin
            t = int'(set_temp) + int'($urandom_range(50)) - 25;
            if (t < 0)
                t = 0;
            if (t > 255)
                t = 255;
            return 8'(t);
        end
        if (r < 90)
            return 8'($urandom_range(255));
        return 8'd0;
    endfunction

    function automatic logic [15:0] pick_secs();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(1, 8));
        if (r < 85)
            return 16'($urandom_range(1, 65535));
        if (r < 95)
            return 16'hFFFF;
        return 16'd0;
    endfunction

    task automatic program_phase(input int phase);
        int t, ov;
        case (phase)
            1: begin
                write_reg(fpd_pkg::CFG_TARGET, 16'd40);
                write_reg(fpd_pkg::CFG_OVERHEAT, 16'd70);
                write_reg(fpd_pkg::CFG_MIN_DUTY, 16'd20);
                write_reg(fpd_pkg::CFG_INIT, 16'd100);
                write_reg(fpd_pkg::CFG_GAIN_P, 16'd512);
                write_reg(fpd_pkg::CFG_GAIN_I, 16'd64);
                write_reg(fpd_pkg::CFG_LIMIT, 16'd5000);
                write_reg(fpd_pkg::CFG_GAIN_D, 16'd300);
                write_reg(fpd_pkg::CFG_IDX_W'(9), 16'hFFFF);
            end
            2: begin
                write_reg(fpd_pkg::CFG_TARGET, 16'hFF00);
                write_reg(fpd_pkg::CFG_OVERHEAT, 16'h00FF);
                write_reg(fpd_pkg::CFG_MIN_DUTY, 16'd0);
                write_reg(fpd_pkg::CFG_INIT, 16'd0);
                write_reg(fpd_pkg::CFG_GAIN_P, 16'h8000);
                write_reg(fpd_pkg::CFG_GAIN_I, 16'h7FFF);
                write_reg(fpd_pkg::CFG_LIMIT, 16'h7FFF);
                write_reg(fpd_pkg::CFG_GAIN_D, 16'h8000);
            end
            3: begin
                write_reg(fpd_pkg::CFG_TARGET, 16'h00FF);
                write_reg(fpd_pkg::CFG_OVERHEAT, 16'hFF00);
                write_reg(fpd_pkg::CFG_MIN_DUTY, 16'h00FF);
                write_reg(fpd_pkg::CFG_INIT, 16'h00FF);
                write_reg(fpd_pkg::CFG_GAIN_P, 16'h7FFF);
                write_reg(fpd_pkg::CFG_GAIN_I, 16'h8000);
                write_reg(fpd_pkg::CFG_LIMIT, 16'h8000);
                write_reg(fpd_pkg::CFG_GAIN_D, 16'h7FFF);
                write_reg(fpd_pkg::CFG_IDX_W'(15), 16'h0000);
            end
            default: begin
                t = $urandom_range(20, 70);
                ov = t + $urandom_range(60);
                if ($urandom_range(4) == 0)
                    ov = $urandom_range(255);
                write_reg(fpd_pkg::CFG_TARGET, {8'($urandom), 8'(t)});
                write_reg(fpd_pkg::CFG_OVERHEAT, {8'($urandom), 8'(ov)});
                write_reg(fpd_pkg::CFG_MIN_DUTY, {8'($urandom), 8'($urandom_range(150))});
                write_reg(fpd_pkg::CFG_INIT, 16'($urandom));
                write_reg(fpd_pkg::CFG_GAIN_P, pick_gain(1024));
                write_reg(fpd_pkg::CFG_GAIN_I, pick_gain(256));
                write_reg(fpd_pkg::CFG_LIMIT, 16'($urandom));
                write_reg(fpd_pkg::CFG_GAIN_D, pick_gain(2048));
                write_reg(fpd_pkg::CFG_IDX_W'($urandom_range(8, 15)), 16'($urandom));
            end
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly complete rounds, mixed with stray items and rounds ending with zero seconds
    task automatic queue_rounds(input int count);
        int n, k, r;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 80) begin
                k = $urandom_range(1, 5);
                repeat (k - 1)
                    add_item(pick_temp(), 1'b0, 16'($urandom));
                add_item(pick_temp(), 1'b1, pick_secs());
                n += k;
            end else if (r < 90) begin
                add_item(8'($urandom), 1'($urandom), 16'($urandom));
                n++;
            end else begin
                k = $urandom_range(0, 3);
                repeat (k)
                    add_item(pick_temp(), 1'b0, 16'($urandom));
                add_item(pick_temp(), 1'b1, 16'd0);
                n += k + 1;
            end
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (poll_q.size() != 0 || in_valid || duty_due_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        set_temp = 8'd37;
        hot_limit = 8'd50;
        duty_floor = 8'd80;
        duty_init = 8'd128;
        k_p = 256;
        k_i = 0;
        integ_cap = 2560;
        k_d = 0;
        hot_temp = '0;
        integ_acc = 0;
        prev_err = 0;
        drive_acc = longint'(duty_init) <<< fpd_pkg::FRAC_BITS;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                send_idle_pct = 38;
                recv_idle_pct = 58;
            end else if (phase < 6) begin
                send_idle_pct = 58;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase > 0)
                program_phase(phase);
            if (phase == 1) begin
                add_item(8'd0, 1'b0, 16'd0);
                add_item(8'd255, 1'b0, 16'hFFFF);
                // zero elapsed time: round maximum dropped, no update
                add_item(8'd10, 1'b1, 16'd0);
                add_item(8'd45, 1'b1, 16'd1);
                add_item(8'd30, 1'b0, 16'd0);
                add_item(8'd50, 1'b0, 16'd0);
                add_item(8'd20, 1'b1, 16'd2);
                add_item(8'd255, 1'b1, 16'hFFFF);
                add_item(8'd0, 1'b1, 16'd1);
                add_item(8'd0, 1'b1, 16'd3);
                add_item(8'd39, 1'b1, 16'd7);
                add_item(8'd40, 1'b1, 16'd1);
                add_item(8'd100, 1'b1, 16'd5);
                // at the overheat limit, then just over it
                add_item(8'd70, 1'b1, 16'd1);
                add_item(8'd71, 1'b1, 16'd1);
                add_item(8'd0, 1'b0, 16'd0);
                add_item(8'd0, 1'b1, 16'd0);
            end
            queue_rounds(PHASE_ITEMS);
            drain();
        end

        if (errors == 0)
            $display("fan_pid_drive_controller_core_test: done, clean");
        else
            $display("fan_pid_drive_controller_core_test: done, errors");
        $finish;
    end

endmodule
